// ----- src/priority_ready_queue_scheduler_defines.svh -----
// assertion helpers shared by the scheduler
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PRQS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PRQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/prqs_pkg.sv -----
package prqs_pkg;

  localparam int TID_W       = 4;
  localparam int MAX_THREADS = 16;
  localparam int LVL_W       = 2;
  localparam int NUM_LVL     = 3;

  typedef logic [TID_W-1:0] tid_t;
  typedef logic [LVL_W-1:0] lvl_t;

  localparam lvl_t LVL_LOW  = 2'd0;
  localparam lvl_t LVL_NORM = 2'd1;
  localparam lvl_t LVL_HIGH = 2'd2;

  typedef enum logic [1:0] {
    ST_DEAD    = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_WAITING = 2'd3
  } thr_st_e;

  typedef enum logic [1:0] {
    K_ACTIVATE  = 2'd0,
    K_BLOCK     = 2'd1,
    K_TERMINATE = 2'd2,
    K_TICK      = 2'd3
  } kind_e;

  localparam tid_t IDLE_TID  = 4'd0;
  localparam tid_t FIRST_TID = 4'd1;

endpackage

// ----- src/prqs_ram.sv -----
module prqs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/priority_ready_queue_scheduler.sv -----
// three-level priority thread scheduler with an idle thread (thread 0)
// input channel s_axis: one scheduling request per transfer; tuser carries the
//   request kind (activate, block, terminate, tick), tdata the target thread
//   and the priority for activate
// output channel m_axis: exactly one result per request: running thread,
//   switch flag and error status
// the ready queues live in one ram (one region per level); a pop or a removal
//   walks the queue region one entry per cycle and shifts the tail down
// a request that touches no queue entries goes from the execute step straight to
//   the finish step; otherwise a walk over every entry of the walked queue lies
//   between them; one request is worked on at a time
// a new request is taken while the previous result still waits in the output
//   register; the finish step holds until that register is free
// reset: all threads dead except thread 1, which runs at normal priority;
//   queues are empty (fill counts cleared, ram contents are don't care)
// a stalled receiver only delays the result, no request is lost
module priority_ready_queue_scheduler
  import prqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [3:0] thread_id, [5:4] prio, [7:6] zero
  input  logic [1:0] s_axis_tuser,   // [1:0] kind
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [3:0] run_id, [4] switched, [5] status, [7:6] zero
);

  `include "priority_ready_queue_scheduler_defines.svh"

  // queue geometry
  localparam int QIW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW      = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_AW  = LVL_W + QIW;
  localparam int RAM_D   = 1 << RAM_AW;
  localparam logic [CW-1:0] QD_C = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   QD_W = (CW+1)'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_FIN
  } state_e;

  state_e           state_q;
  kind_e            kind_q;
  tid_t             id_q;
  lvl_t             pr_q;

  thr_st_e          status_q [MAX_THREADS];
  lvl_t             prio_q   [MAX_THREADS];
  logic [CW-1:0]    cnt_q    [NUM_LVL];
  tid_t             cur_q;

  // walk engine
  lvl_t             wlvl_q;
  tid_t             wid_q;
  logic             wpop_q;
  logic [CW-1:0]    rd_idx_q;
  logic [CW-1:0]    ri_q;
  logic             rvalid_q;
  logic             found_q;
  tid_t             nid_q;

  // finish step
  logic             err_q;
  logic             run_chg_q;
  logic             push_pend_q;
  lvl_t             push_lvl_q;

  logic             out_valid_q;
  tid_t             out_run_q;
  logic             out_sw_q;
  logic             out_err_q;

  // ram ports
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  tid_t              ram_wdata;
  logic [RAM_AW-1:0] ram_raddr;
  tid_t              ram_rdata;

  prqs_ram #(
    .WIDTH (TID_W),
    .DEPTH (RAM_D)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // request decode
  lvl_t    in_pr;
  lvl_t    cur_prio;
  thr_st_e id_st;
  logic    act_ok;
  logic    term_ok;
  logic    top_v;
  lvl_t    top_l;
  lvl_t    top_a;
  logic    rot_req;
  lvl_t    rot_l;
  logic    disp_req;
  logic    p_full;
  logic    fin_go;
  logic    walk_issue;
  logic    walk_done;
  logic    walk_match;
  tid_t    fin_nid;
  logic    cnt_in_range;

  // outcome of the execute step
  logic    exec_err;
  logic    exec_walk;
  logic    exec_wpop;
  lvl_t    exec_wlvl;
  logic    exec_rot;

  assign in_pr    = (s_axis_tdata[5:4] == 2'd3) ? LVL_HIGH : s_axis_tdata[5:4];
  assign cur_prio = prio_q[cur_q];
  assign id_st    = status_q[id_q];

  // ids are 4 bits wide, so every id below MAX_THREADS is in range
  assign act_ok  = (id_q != IDLE_TID) && (id_st == ST_DEAD) && (cnt_q[pr_q] < QD_C);
  assign term_ok = (id_q != IDLE_TID) && (id_st != ST_DEAD);

  always_comb begin
    // highest non-empty level as the queues stand
    top_v = 1'b1;
    if (cnt_q[LVL_HIGH] != '0) begin
      top_l = LVL_HIGH;
    end else if (cnt_q[LVL_NORM] != '0) begin
      top_l = LVL_NORM;
    end else begin
      top_l = LVL_LOW;
      top_v = (cnt_q[LVL_LOW] != '0);
    end
    // highest level once the activated thread is queued
    if (cnt_q[LVL_HIGH] != '0 || pr_q == LVL_HIGH) begin
      top_a = LVL_HIGH;
    end else if (cnt_q[LVL_NORM] != '0 || pr_q == LVL_NORM) begin
      top_a = LVL_NORM;
    end else begin
      top_a = LVL_LOW;
    end
  end

  always_comb begin
    rot_req  = 1'b0;
    rot_l    = top_l;
    disp_req = 1'b0;
    case (kind_q)
      K_ACTIVATE: begin
        rot_req = act_ok && ((cur_q == IDLE_TID) || (pr_q > cur_prio));
        rot_l   = top_a;
      end
      K_BLOCK: disp_req = (cur_q != IDLE_TID);
      K_TERMINATE: disp_req = term_ok && (id_q == cur_q);
      default: rot_req = top_v && ((cur_q == IDLE_TID) || (top_l >= cur_prio));
    endcase
    // displaced thread's queue, counting an activation pushed this request
    p_full = (({1'b0, cnt_q[cur_prio]}
              + (CW+1)'((kind_q == K_ACTIVATE) && (cur_prio == pr_q))) >= QD_W);

    exec_err  = 1'b0;
    exec_walk = 1'b0;
    exec_wpop = 1'b1;
    exec_wlvl = top_l;
    exec_rot  = 1'b0;
    case (kind_q)
      K_ACTIVATE: exec_err = !act_ok;
      K_BLOCK: exec_err = (cur_q == IDLE_TID);
      K_TERMINATE: begin
        exec_err = !term_ok;
        // a ready thread leaves the middle of its queue
        if (term_ok && (id_q != cur_q) && (id_st == ST_READY)) begin
          exec_walk = 1'b1;
          exec_wpop = 1'b0;
          exec_wlvl = prio_q[id_q];
        end
      end
      default: exec_err = 1'b0;
    endcase
    // displace the running thread by the head of rot_l, unless its queue is another level and full
    if (rot_req && ((cur_q == IDLE_TID) || !(cur_prio != rot_l && p_full))) begin
      exec_rot  = 1'b1;
      exec_walk = 1'b1;
      exec_wlvl = rot_l;
    end
    // running thread has left: head of the top queue, or idle
    if (disp_req) begin
      exec_walk = top_v;
      exec_wlvl = top_l;
    end
  end

  assign walk_issue = (rd_idx_q < cnt_q[wlvl_q]);
  assign walk_done  = !rvalid_q && !walk_issue;
  assign walk_match = wpop_q ? (ri_q == '0) : (ram_rdata == wid_q);
  assign fin_go     = !out_valid_q || m_axis_tready;
  assign fin_nid    = nid_q;

  // ram port selection: push on activate, shift during a walk, push back on finish
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {pr_q, cnt_q[pr_q][QIW-1:0]};
    ram_wdata = id_q;
    ram_raddr = {wlvl_q, rd_idx_q[QIW-1:0]};
    unique case (state_q)
      S_EXEC: ram_we = (kind_q == K_ACTIVATE) && act_ok;
      S_WALK: begin
        ram_we    = rvalid_q && found_q;
        ram_waddr = {wlvl_q, QIW'(ri_q - CW'(1))};
        ram_wdata = ram_rdata;
      end
      S_FIN: begin
        ram_we    = fin_go && run_chg_q && push_pend_q;
        ram_waddr = {push_lvl_q, cnt_q[push_lvl_q][QIW-1:0]};
        ram_wdata = cur_q;
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= K_ACTIVATE;
      id_q        <= IDLE_TID;
      pr_q        <= LVL_LOW;
      for (int i = 0; i < MAX_THREADS; i++) begin
        status_q[i] <= ST_DEAD;
        prio_q[i]   <= LVL_LOW;
      end
      status_q[FIRST_TID] <= ST_RUNNING;
      prio_q[FIRST_TID]   <= LVL_NORM;
      for (int l = 0; l < NUM_LVL; l++) begin
        cnt_q[l] <= '0;
      end
      cur_q       <= FIRST_TID;
      wlvl_q      <= LVL_LOW;
      wid_q       <= IDLE_TID;
      wpop_q      <= 1'b0;
      rvalid_q    <= 1'b0;
      found_q     <= 1'b0;
      rd_idx_q    <= '0;
      ri_q        <= '0;
      nid_q       <= IDLE_TID;
      run_chg_q   <= 1'b0;
      push_pend_q <= 1'b0;
      push_lvl_q  <= LVL_LOW;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_run_q   <= IDLE_TID;
      out_sw_q    <= 1'b0;
      out_err_q   <= 1'b0;
    end else begin
      if (state_q == S_FIN && fin_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            kind_q  <= kind_e'(s_axis_tuser);
            id_q    <= s_axis_tdata[3:0];
            pr_q    <= in_pr;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          err_q       <= exec_err;
          run_chg_q   <= exec_rot || disp_req;
          push_pend_q <= exec_rot && (cur_q != IDLE_TID);
          push_lvl_q  <= cur_prio;
          found_q     <= 1'b0;
          rvalid_q    <= 1'b0;
          rd_idx_q    <= '0;
          wpop_q      <= exec_wpop;
          wlvl_q      <= exec_wlvl;
          wid_q       <= id_q;
          nid_q       <= IDLE_TID;
          state_q     <= exec_walk ? S_WALK : S_FIN;
          unique case (kind_q)
            K_ACTIVATE: begin
              if (act_ok) begin
                prio_q[id_q]   <= pr_q;
                status_q[id_q] <= ST_READY;
                cnt_q[pr_q]    <= cnt_q[pr_q] + CW'(1);
              end
            end
            K_BLOCK: begin
              if (!exec_err) begin
                status_q[cur_q] <= ST_WAITING;
              end
            end
            K_TERMINATE: begin
              if (!exec_err) begin
                status_q[id_q] <= ST_DEAD;
              end
            end
            default: ;
          endcase
          // the displaced thread (idle included) becomes ready
          if (exec_rot) begin
            status_q[cur_q] <= ST_READY;
          end
        end
        S_WALK: begin
          rvalid_q <= walk_issue;
          if (walk_issue) begin
            rd_idx_q <= rd_idx_q + CW'(1);
            ri_q     <= rd_idx_q;
          end
          if (rvalid_q && !found_q && walk_match) begin
            found_q <= 1'b1;
            nid_q   <= ram_rdata;
          end
          if (walk_done) begin
            cnt_q[wlvl_q] <= cnt_q[wlvl_q] - CW'(1);
            state_q       <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            out_err_q <= err_q;
            if (run_chg_q) begin
              status_q[fin_nid] <= ST_RUNNING;
              cur_q     <= fin_nid;
              out_run_q <= fin_nid;
              out_sw_q  <= (fin_nid != cur_q);
              if (push_pend_q) begin
                cnt_q[push_lvl_q] <= cnt_q[push_lvl_q] + CW'(1);
              end
            end else begin
              out_run_q <= cur_q;
              out_sw_q  <= 1'b0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_err_q, out_sw_q, out_run_q};

  // checks
  assign cnt_in_range = (cnt_q[0] <= QD_C) && (cnt_q[1] <= QD_C) && (cnt_q[2] <= QD_C);

  `PRQS_ASSERT(a_cnt_bound, 1'b1, cnt_in_range, "queue fill above depth")
  `PRQS_ASSERT(a_cur_running, state_q == S_IDLE, status_q[cur_q] == ST_RUNNING, "bad current")
  `PRQS_ASSERT(a_walk_found, state_q == S_WALK && walk_done, found_q, "walk missed")
  `PRQS_ASSERT_NEXT(a_accept_exec, s_axis_tvalid && s_axis_tready, state_q == S_EXEC, "no exec")

endmodule

// ----- sim/tb_priority_ready_queue_scheduler.sv -----
`timescale 1ns / 1ps

module tb_priority_ready_queue_scheduler;
  import prqs_pkg::*;

  localparam int QDEPTH    = 16;
  localparam int CYC_LIMIT = 400000;
  localparam int N_RANDOM  = 1100;

  typedef struct packed {
    tid_t run_id;
    logic switched;
    logic status;
  } sched_res_t;

  typedef struct {
    kind_e kind;
    tid_t  tid;
    logic [1:0] prio;
    logic  has_exp;
    sched_res_t exp;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // [3:0] thread_id, [5:4] prio, [7:6] zero
  logic [1:0] s_axis_tuser = '0;   // [1:0] kind
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // [3:0] run_id, [4] switched, [5] status, [7:6] zero

  priority_ready_queue_scheduler #(.QUEUE_DEPTH(QDEPTH)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // shadow scheduler state
  tid_t    rq [3][$];
  thr_st_e tstate [MAX_THREADS];
  lvl_t    tprio [MAX_THREADS];
  tid_t    running;

  sched_res_t pending_res [$];
  int  n_err = 0;
  int  n_res = 0;
  int  cycles = 0;
  int  hold_cycles = 0;
  int  n_switch = 0, n_status = 0;

  function automatic void sched_reset();
    for (int l = 0; l < 3; l++) rq[l].delete();
    for (int t = 0; t < MAX_THREADS; t++) begin
      tstate[t] = ST_DEAD;
      tprio[t] = LVL_LOW;
    end
    tstate[FIRST_TID] = ST_RUNNING;
    tprio[FIRST_TID] = LVL_NORM;
    running = FIRST_TID;
  endfunction

  function automatic int top_lvl();
    for (int l = 2; l >= 0; l--) if (rq[l].size() != 0) return l;
    return -1;
  endfunction

  function automatic void run_next();
    int l;
    tid_t nid;
    l = top_lvl();
    nid = IDLE_TID;
    if (l >= 0) nid = rq[l].pop_front();
    tstate[nid] = ST_RUNNING;
    running = nid;
  endfunction

  // displace the running thread by the head of level lvl
  function automatic void preempt(int lvl);
    tid_t cur, nid;
    int p;
    cur = running;
    if (cur == IDLE_TID) begin
      nid = rq[lvl].pop_front();
      tstate[IDLE_TID] = ST_READY;
    end else begin
      p = tprio[cur];
      // displaced thread has no room: no switch
      if (p != lvl && rq[p].size() >= QDEPTH) return;
      nid = rq[lvl].pop_front();
      rq[p].insert(rq[p].size(), cur);
      tstate[cur] = ST_READY;
    end
    tstate[nid] = ST_RUNNING;
    running = nid;
  endfunction

  function automatic sched_res_t sched_event(kind_e k, tid_t id, logic [1:0] pr_in);
    tid_t was;
    logic err;
    int l, pr;
    sched_res_t r;
    was = running;
    err = 1'b0;
    pr = (pr_in > 2) ? 2 : pr_in;   // prio three counts as high
    case (k)
      K_ACTIVATE: begin
        if (id == IDLE_TID || tstate[id] != ST_DEAD || rq[pr].size() >= QDEPTH) begin
          err = 1'b1;
        end else begin
          tprio[id] = lvl_t'(pr);
          tstate[id] = ST_READY;
          rq[pr].insert(rq[pr].size(), id);
          if (running == IDLE_TID || pr > tprio[running]) begin
            l = top_lvl();
            if (l >= 0) preempt(l);
          end
        end
      end
      K_BLOCK: begin
        if (running == IDLE_TID) begin
          err = 1'b1;
        end else begin
          tstate[running] = ST_WAITING;
          run_next();
        end
      end
      K_TERMINATE: begin
        if (id == IDLE_TID || tstate[id] == ST_DEAD) begin
          err = 1'b1;
        end else if (id == running) begin
          tstate[id] = ST_DEAD;
          run_next();
        end else begin
          if (tstate[id] == ST_READY) begin
            for (int i = 0; i < rq[tprio[id]].size(); i++)
              if (rq[tprio[id]][i] == id) begin
                rq[tprio[id]].delete(i);
                break;
              end
          end
          tstate[id] = ST_DEAD;
        end
      end
      default: begin
        // tick rotates only to equal or higher priority
        l = top_lvl();
        if (l >= 0 && (running == IDLE_TID || l >= tprio[running])) preempt(l);
      end
    endcase
    r.run_id = running;
    r.switched = (running != was);
    r.status = err;
    return r;
  endfunction

  // directed rows: typed expectations only for obvious cases
  localparam int N_DIR = 22;
  stim_row_t dir_rows [N_DIR];

  function automatic stim_row_t mk(kind_e k, int id, int pr, bit he,
                                   int rid = 0, int sw = 0, int st = 0);
    stim_row_t r;
    r.kind = k; r.tid = tid_t'(id); r.prio = pr[1:0]; r.has_exp = he;
    r.exp.run_id = tid_t'(rid); r.exp.switched = sw[0]; r.exp.status = st[0];
    return r;
  endfunction

  initial begin
    dir_rows[0]  = mk(K_TICK,      0,  0, 1, 1, 0, 0);  // tick with empty queues
    dir_rows[1]  = mk(K_ACTIVATE,  0,  1, 1, 1, 0, 1);  // idle as target
    dir_rows[2]  = mk(K_ACTIVATE,  1,  1, 1, 1, 0, 1);  // running thread is live
    dir_rows[3]  = mk(K_TERMINATE, 15, 0, 1, 1, 0, 1);  // dead thread
    dir_rows[4]  = mk(K_ACTIVATE,  15, 0, 0);
    dir_rows[5]  = mk(K_ACTIVATE,  2,  1, 0);
    dir_rows[6]  = mk(K_TICK,      0,  0, 0);
    dir_rows[7]  = mk(K_ACTIVATE,  3,  3, 0);           // prio three as high
    dir_rows[8]  = mk(K_ACTIVATE,  4,  2, 0);
    dir_rows[9]  = mk(K_TICK,      0,  0, 0);
    dir_rows[10] = mk(K_TERMINATE, 2,  0, 0);           // ready thread leaves queue
    dir_rows[11] = mk(K_BLOCK,     0,  0, 0);
    dir_rows[12] = mk(K_TERMINATE, 0,  0, 0);           // idle as target
    dir_rows[13] = mk(K_TERMINATE, 4,  0, 0);           // terminate waiting
    dir_rows[14] = mk(K_TERMINATE, 3,  0, 0);           // terminate running
    dir_rows[15] = mk(K_BLOCK,     0,  0, 0);
    dir_rows[16] = mk(K_BLOCK,     0,  0, 0);
    dir_rows[17] = mk(K_BLOCK,     0,  0, 0);
    dir_rows[18] = mk(K_BLOCK,     0,  0, 0);           // block while idle
    dir_rows[19] = mk(K_TICK,      0,  0, 0);           // tick while idle
    dir_rows[20] = mk(K_ACTIVATE,  9,  0, 0);           // activate while idle
    dir_rows[21] = mk(K_TERMINATE, 9,  0, 0);           // terminate running
  end

  // sender: one request at the falling edge, held until taken
  task automatic send_req(kind_e k, tid_t id, logic [1:0] pr, bit he, sched_res_t ex);
    sched_res_t p;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {2'b00, pr, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    p = sched_event(k, id, pr);
    if (he && p !== ex) begin
      n_err++;
      $display("directed row predictor disagrees: %h vs %h", p, ex);
    end
    pending_res.insert(pending_res.size(), he ? ex : p);
    @(negedge clk_i);
  endtask

  task automatic idle_sender(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain_wait();
    s_axis_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk_i);
    repeat (25) @(negedge clk_i);
  endtask

  // activations in 45 of every 100 requests on average so the queues fill, plus noise
  task automatic rand_req();
    kind_e k;
    tid_t id;
    logic [1:0] pr;
    int r;
    sched_res_t nx;
    r = $urandom_range(99);
    if (r < 45) k = K_ACTIVATE;
    else if (r < 60) k = K_BLOCK;
    else if (r < 78) k = K_TERMINATE;
    else k = K_TICK;
    id = tid_t'($urandom_range(15));
    pr = 2'($urandom_range(3));
    nx = '0;
    send_req(k, id, pr, 1'b0, nx);
  endtask

  // receiver stall pattern, with one long hold-off
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (cycles % 512 < 128) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(3) != 0);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    sched_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.run_id   = m_axis_tdata[3:0];
      got.switched = m_axis_tdata[4];
      got.status   = m_axis_tdata[5];
      n_res++;
      if (pending_res.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        want = pending_res.pop_front();
        if (got.switched) n_switch++;
        if (got.status) n_status++;
        if (got.run_id !== want.run_id || got.switched !== want.switched ||
            got.status !== want.status || m_axis_tdata[7:6] !== 2'b00) begin
          n_err++;
          if (n_err <= 10)
            $display("result %0d: exp run=%0d sw=%0b st=%0b got run=%0d sw=%0b st=%0b",
                     n_res, want.run_id, want.switched, want.status,
                     got.run_id, got.switched, got.status);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYC_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("priority_ready_queue_scheduler test failed");
      $finish;
    end
  end

  initial begin
    int sent;
    sched_reset();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < N_DIR; i++) begin
      send_req(dir_rows[i].kind, dir_rows[i].tid, dir_rows[i].prio,
               dir_rows[i].has_exp, dir_rows[i].exp);
      if ($urandom_range(2) == 0) idle_sender($urandom_range(1, 4));
    end

    // sender pauses until everything has come back
    drain_wait();

    // long receiver hold-off while the sender keeps offering
    hold_cycles <= 300;
    for (int i = 0; i < 20; i++) rand_req();

    sent = 0;
    while (sent < N_RANDOM) begin
      int burst;
      burst = $urandom_range(1, 30);
      for (int b = 0; b < burst && sent < N_RANDOM; b++) begin
        rand_req();
        sent++;
      end
      if ($urandom_range(3) != 0) idle_sender($urandom_range(1, 40));
    end

    drain_wait();
    $display("checked %0d scheduling results: %0d switches, %0d error statuses",
             n_res, n_switch, n_status);
    if (n_err == 0) begin
      $display("priority_ready_queue_scheduler test passed");
    end else begin
      $display("%0d mismatches", n_err);
      $display("priority_ready_queue_scheduler test failed");
    end
    $finish;
  end

endmodule
